>>> hw/rtl/tpwrms_pkg.sv
// Package for the three-phase windowed RMS block: sizes, payload structs,
// unit step controls and controller state codes.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package tpwrms_pkg;

	localparam int WINDOW_LEN  = 80;
	localparam int SAMPLE_BITS = 24;
	localparam int MEAN_DIV    = 3;

	localparam int IN_W      = 24;
	localparam int OUT_W     = 24;
	localparam int NEU_OUT_W = 25;

	localparam int ACC_W  = 56;
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int MAG_W  = SAMPLE_BITS + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SQRT_W = ACC_W / 2;
	localparam int DIVR_W = ($clog2(WINDOW_LEN + 1) > 2) ? $clog2(WINDOW_LEN + 1) : 2;
	localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W  = $clog2(ACC_W + 1);

	typedef struct packed {
		logic signed [IN_W-1:0] phase_a_sample;
		logic signed [IN_W-1:0] phase_b_sample;
		logic signed [IN_W-1:0] phase_c_sample;
		logic signed [IN_W-1:0] neutral_sample;
	} sample_set_t;

	typedef struct packed {
		logic [OUT_W-1:0]     rms_phase_a;
		logic [OUT_W-1:0]     rms_phase_b;
		logic [OUT_W-1:0]     rms_phase_c;
		logic [NEU_OUT_W-1:0] rms_neutral;
		logic [OUT_W-1:0]     rms_phase_mean;
	} rms_set_t;

	typedef struct packed {
		logic load;
		logic run;
	} step_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SQUARE = 7'b0000010,
		ST_ACCUM  = 7'b0000100,
		ST_DIVIDE = 7'b0001000,
		ST_ROOT   = 7'b0010000,
		ST_MEAN   = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

endpackage

>>> hw/rtl/three_phase_windowed_rms.sv
// Three-phase windowed RMS top level: controller, accumulators, output register.
// Depends on tpwrms_pkg, tpwrms_sqr, tpwrms_div, tpwrms_isqrt.
// Throughput is set by the bit-serial squarers: a new request stalls until the last is accumulated.
// At window end it divides by WINDOW_LEN, takes the square root, and divides the sum of
// the three phase roots by three; the result then waits in ST_OUT for a free output.
// Reset clears the accumulators, the window position, the controller and the output valid.
module three_phase_windowed_rms (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  tpwrms_pkg::sample_set_t sample,
	output logic                    rms_valid,
	input  logic                    rms_stall,
	output tpwrms_pkg::rms_set_t    rms
);

	tpwrms_pkg::state_t state_q;
	logic [tpwrms_pkg::CNT_W-1:0]  cnt_q;
	logic [tpwrms_pkg::POS_W-1:0]  pos_q;
	logic [tpwrms_pkg::ACC_W-1:0]  acc_q [4];
	tpwrms_pkg::rms_set_t          rms_q;
	logic                          rms_valid_q;

	logic signed [tpwrms_pkg::SUM_W-1:0] chan [4];
	logic signed [tpwrms_pkg::SUM_W-1:0] ext_n;
	logic [tpwrms_pkg::MAG_W-1:0]  mag [4];
	logic [tpwrms_pkg::SQ_W-1:0]   sq [4];
	logic [tpwrms_pkg::ACC_W:0]    acc_sum [4];
	logic [tpwrms_pkg::ACC_W-1:0]  acc_sat [4];
	logic [tpwrms_pkg::ACC_W-1:0]  quo [4];
	logic [tpwrms_pkg::SQRT_W-1:0] root [4];
	logic [tpwrms_pkg::ACC_W-1:0]  mean_sum;
	logic [tpwrms_pkg::ACC_W-1:0]  div0_in;
	logic [tpwrms_pkg::DIVR_W-1:0] div0_dsr;

	logic accept;
	logic last;
	logic out_free;
	tpwrms_pkg::step_t sqr_step;
	tpwrms_pkg::step_t div_step;
	tpwrms_pkg::step_t div0_step;
	tpwrms_pkg::step_t root_step;

	assign sample_stall = state_q != tpwrms_pkg::ST_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign last         = pos_q == tpwrms_pkg::POS_W'(tpwrms_pkg::WINDOW_LEN - 1);
	assign out_free     = !rms_valid_q || !rms_stall;

	// sign-extend the low sample bits; zero neutral selects the phase sum
	assign chan[0] = tpwrms_pkg::SUM_W'(signed'(sample.phase_a_sample[tpwrms_pkg::SAMPLE_BITS-1:0]));
	assign chan[1] = tpwrms_pkg::SUM_W'(signed'(sample.phase_b_sample[tpwrms_pkg::SAMPLE_BITS-1:0]));
	assign chan[2] = tpwrms_pkg::SUM_W'(signed'(sample.phase_c_sample[tpwrms_pkg::SAMPLE_BITS-1:0]));
	assign ext_n   = tpwrms_pkg::SUM_W'(signed'(sample.neutral_sample[tpwrms_pkg::SAMPLE_BITS-1:0]));
	assign chan[3] = (ext_n == '0) ? chan[0] + chan[1] + chan[2] : ext_n;

	assign sqr_step  = '{load: accept, run: state_q == tpwrms_pkg::ST_SQUARE};
	assign div_step  = '{load: state_q == tpwrms_pkg::ST_ACCUM && last,
		run: state_q == tpwrms_pkg::ST_DIVIDE};
	assign div0_step = '{load: div_step.load || (state_q == tpwrms_pkg::ST_MEAN && cnt_q == '0),
		run: div_step.run || (state_q == tpwrms_pkg::ST_MEAN && cnt_q != '0)};
	assign root_step = '{load: state_q == tpwrms_pkg::ST_ROOT && cnt_q == '0,
		run: state_q == tpwrms_pkg::ST_ROOT && cnt_q != '0};

	assign mean_sum = tpwrms_pkg::ACC_W'(root[0]) + tpwrms_pkg::ACC_W'(root[1])
		+ tpwrms_pkg::ACC_W'(root[2]);
	assign div0_in  = (state_q == tpwrms_pkg::ST_MEAN) ? mean_sum : acc_sat[0];
	assign div0_dsr = (state_q == tpwrms_pkg::ST_MEAN)
		? tpwrms_pkg::DIVR_W'(tpwrms_pkg::MEAN_DIV)
		: tpwrms_pkg::DIVR_W'(tpwrms_pkg::WINDOW_LEN);

	for (genvar k = 0; k < 4; k++) begin : g_lane
		assign mag[k] = chan[k][tpwrms_pkg::SUM_W-1]
			? tpwrms_pkg::MAG_W'(-chan[k]) : tpwrms_pkg::MAG_W'(chan[k]);
		assign acc_sum[k] = {1'b0, acc_q[k]} + (tpwrms_pkg::ACC_W + 1)'(sq[k]);
		assign acc_sat[k] = acc_sum[k][tpwrms_pkg::ACC_W] ? '1
			: acc_sum[k][tpwrms_pkg::ACC_W-1:0];

		tpwrms_sqr u_sqr (
			.clk  (clk),
			.step (sqr_step),
			.mag  (mag[k]),
			.sq   (sq[k])
		);

		if (k == 0) begin : g_div_shared
			tpwrms_div u_div (
				.clk      (clk),
				.step     (div0_step),
				.dividend (div0_in),
				.divisor  (div0_dsr),
				.quotient (quo[k])
			);
		end else begin : g_div
			tpwrms_div u_div (
				.clk      (clk),
				.step     (div_step),
				.dividend (acc_sat[k]),
				.divisor  (tpwrms_pkg::DIVR_W'(tpwrms_pkg::WINDOW_LEN)),
				.quotient (quo[k])
			);
		end

		tpwrms_isqrt u_isqrt (
			.clk      (clk),
			.step     (root_step),
			.radicand (quo[k]),
			.root     (root[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[k] <= '0;
			end else if (state_q == tpwrms_pkg::ST_ACCUM) begin
				acc_q[k] <= last ? '0 : acc_sat[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpwrms_pkg::ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				tpwrms_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= tpwrms_pkg::ST_SQUARE;
					end
				end
				tpwrms_pkg::ST_SQUARE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tpwrms_pkg::CNT_W'(tpwrms_pkg::MAG_W - 1)) begin
						cnt_q   <= '0;
						state_q <= tpwrms_pkg::ST_ACCUM;
					end
				end
				tpwrms_pkg::ST_ACCUM: begin
					cnt_q <= '0;
					if (last) begin
						pos_q   <= '0;
						state_q <= tpwrms_pkg::ST_DIVIDE;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= tpwrms_pkg::ST_IDLE;
					end
				end
				tpwrms_pkg::ST_DIVIDE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tpwrms_pkg::CNT_W'(tpwrms_pkg::ACC_W - 1)) begin
						cnt_q   <= '0;
						state_q <= tpwrms_pkg::ST_ROOT;
					end
				end
				tpwrms_pkg::ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tpwrms_pkg::CNT_W'(tpwrms_pkg::SQRT_W)) begin
						cnt_q   <= '0;
						state_q <= tpwrms_pkg::ST_MEAN;
					end
				end
				tpwrms_pkg::ST_MEAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tpwrms_pkg::CNT_W'(tpwrms_pkg::ACC_W)) begin
						cnt_q   <= '0;
						state_q <= tpwrms_pkg::ST_OUT;
					end
				end
				tpwrms_pkg::ST_OUT: begin
					cnt_q <= '0;
					if (out_free) begin
						state_q <= tpwrms_pkg::ST_IDLE;
					end
				end
				default: begin
					cnt_q   <= '0;
					state_q <= tpwrms_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rms_valid_q <= 1'b0;
		end else if (state_q == tpwrms_pkg::ST_OUT && out_free) begin
			rms_valid_q <= 1'b1;
		end else if (!rms_stall) begin
			rms_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tpwrms_pkg::ST_OUT && out_free) begin
			rms_q.rms_phase_a    <= root[0][tpwrms_pkg::OUT_W-1:0];
			rms_q.rms_phase_b    <= root[1][tpwrms_pkg::OUT_W-1:0];
			rms_q.rms_phase_c    <= root[2][tpwrms_pkg::OUT_W-1:0];
			rms_q.rms_neutral    <= root[3][tpwrms_pkg::NEU_OUT_W-1:0];
			rms_q.rms_phase_mean <= quo[0][tpwrms_pkg::OUT_W-1:0];
		end
	end

	assign rms_valid = rms_valid_q;
	assign rms       = rms_q;

endmodule

>>> hw/rtl/tpwrms_sqr.sv
// Bit-serial squarer: shift-and-add, one multiplier bit per step.
// Depends on tpwrms_pkg.
module tpwrms_sqr (
	input  logic                        clk,
	input  tpwrms_pkg::step_t           step,
	input  logic [tpwrms_pkg::MAG_W-1:0] mag,
	output logic [tpwrms_pkg::SQ_W-1:0]  sq
);

	logic [tpwrms_pkg::MAG_W-1:0] mcand_q;
	logic [tpwrms_pkg::SQ_W-1:0]  prod_q;
	logic [tpwrms_pkg::MAG_W:0]   psum;

	assign psum = {1'b0, prod_q[tpwrms_pkg::SQ_W-1:tpwrms_pkg::MAG_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk) begin
		if (step.load) begin
			mcand_q <= mag;
			prod_q  <= tpwrms_pkg::SQ_W'(mag);
		end else if (step.run) begin
			prod_q <= {psum, prod_q[tpwrms_pkg::MAG_W-1:1]};
		end
	end

	assign sq = prod_q;

endmodule

>>> hw/rtl/tpwrms_div.sv
// Bit-serial restoring divider by a narrow divisor, one quotient bit per step.
// Depends on tpwrms_pkg.
module tpwrms_div (
	input  logic                          clk,
	input  tpwrms_pkg::step_t             step,
	input  logic [tpwrms_pkg::ACC_W-1:0]  dividend,
	input  logic [tpwrms_pkg::DIVR_W-1:0] divisor,
	output logic [tpwrms_pkg::ACC_W-1:0]  quotient
);

	logic [tpwrms_pkg::ACC_W-1:0]  quo_q;
	logic [tpwrms_pkg::DIVR_W-1:0] rem_q;
	logic [tpwrms_pkg::DIVR_W-1:0] dsr_q;
	logic [tpwrms_pkg::DIVR_W:0]   trial;
	logic [tpwrms_pkg::DIVR_W:0]   diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[tpwrms_pkg::ACC_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (step.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step.run) begin
			rem_q <= ge ? diff[tpwrms_pkg::DIVR_W-1:0] : trial[tpwrms_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[tpwrms_pkg::ACC_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

>>> hw/rtl/tpwrms_isqrt.sv
// Digit-serial floored integer square root, two radicand bits per step.
// Depends on tpwrms_pkg.
module tpwrms_isqrt (
	input  logic                          clk,
	input  tpwrms_pkg::step_t             step,
	input  logic [tpwrms_pkg::ACC_W-1:0]  radicand,
	output logic [tpwrms_pkg::SQRT_W-1:0] root
);

	logic [tpwrms_pkg::ACC_W-1:0]  rad_q;
	logic [tpwrms_pkg::SQRT_W-1:0] root_q;
	logic [tpwrms_pkg::SQRT_W+1:0] rem_q;
	logic [tpwrms_pkg::SQRT_W+3:0] trial;
	logic [tpwrms_pkg::SQRT_W+3:0] test;
	logic [tpwrms_pkg::SQRT_W+3:0] diff;
	logic                          ge;

	assign trial = {rem_q, rad_q[tpwrms_pkg::ACC_W-1 -: 2]};
	assign test  = {2'b00, root_q, 2'b01};
	assign ge    = trial >= test;
	assign diff  = trial - test;

	always_ff @(posedge clk) begin
		if (step.load) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (step.run) begin
			rem_q  <= ge ? diff[tpwrms_pkg::SQRT_W+1:0] : trial[tpwrms_pkg::SQRT_W+1:0];
			root_q <= {root_q[tpwrms_pkg::SQRT_W-2:0], ge};
			rad_q  <= {rad_q[tpwrms_pkg::ACC_W-3:0], 2'b00};
		end
	end

	assign root = root_q;

endmodule
